FILE: design/quaternion_to_rotation_matrix_defines.svh
// Assertion macros for the quaternion to rotation matrix block.
// Included by the top level; relies on i_clk and i_rst_n in scope.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Implication checked at every clock, off during reset
`define QRM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define QRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies.
`timescale 1ns / 1ps

package qrm_pkg;

    // Width of one output matrix entry
    localparam int OUT_W = 16;

    // Row numbers
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    // Sideband traveling with each row through the divider
    typedef struct packed {
        logic [1:0] row;
        logic       degen;
        logic       last;
    } t_side;

endpackage

FILE: design/qrm_products.sv
// Two-stage front end: ten products, then nine numerators and the squared norm.
// Depends on qrm_pkg.
`timescale 1ns / 1ps

module qrm_products
    import qrm_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [W-1:0]   i_w,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    input  logic signed [W-1:0]   i_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [2*W+1:0] o_m [9],
    output logic [2*W:0]          o_n,
    output logic                  o_degen
);

    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 2;

    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_p [10];
    logic signed [NW-1:0] r_m [9];
    logic [2*W:0]         r_n;
    logic                 s1_free, s2_free;
    logic signed [NW-1:0] n_m [9];
    logic signed [NW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, n_sum;

    assign s2_free = !r_v2 || i_ready;
    assign s1_free = !r_v1 || s2_free;
    assign o_ready = s1_free;

    // Stage 1 valid and stage 2 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_free) r_v1 <= i_valid;
            if (s2_free) r_v2 <= r_v1;
        end
    end

    // Stage 1: products
    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_p[0] <= i_w * i_w;
            r_p[1] <= i_x * i_x;
            r_p[2] <= i_y * i_y;
            r_p[3] <= i_z * i_z;
            r_p[4] <= i_x * i_y;
            r_p[5] <= i_x * i_z;
            r_p[6] <= i_y * i_z;
            r_p[7] <= i_w * i_x;
            r_p[8] <= i_w * i_y;
            r_p[9] <= i_w * i_z;
        end
    end

    // Stage 2 sums
    always_comb begin
        ww = NW'(r_p[0]); xx = NW'(r_p[1]); yy = NW'(r_p[2]); zz = NW'(r_p[3]);
        xy = NW'(r_p[4]); xz = NW'(r_p[5]); yz = NW'(r_p[6]);
        wx = NW'(r_p[7]); wy = NW'(r_p[8]); wz = NW'(r_p[9]);
        n_m[0] = ww + xx - yy - zz;
        n_m[1] = (xy - wz) <<< 1;
        n_m[2] = (xz + wy) <<< 1;
        n_m[3] = (xy + wz) <<< 1;
        n_m[4] = ww - xx + yy - zz;
        n_m[5] = (yz - wx) <<< 1;
        n_m[6] = (xz - wy) <<< 1;
        n_m[7] = (yz + wx) <<< 1;
        n_m[8] = ww - xx - yy + zz;
        n_sum  = ww + xx + yy + zz;
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_v1) begin
            r_m <= n_m;
            r_n <= n_sum[2*W:0];
        end
    end

    assign o_valid = r_v2;
    assign o_m     = r_m;
    assign o_n     = r_n;
    assign o_degen = (r_n == '0);

endmodule

FILE: design/qrm_row_seq.sv
// Holds one quaternion's numerators and issues its four rows, one per enabled cycle.
// Depends on qrm_pkg.
`timescale 1ns / 1ps

module qrm_row_seq
    import qrm_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [2*W+1:0] i_m [9],
    input  logic [2*W:0]          i_n,
    input  logic                  i_degen,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic signed [2*W+1:0] o_num [3],
    output logic [2*W:0]          o_n
);

    logic                  r_hv;
    logic [1:0]            r_row;
    logic signed [2*W+1:0] r_m [9];
    logic [2*W:0]          r_n;
    logic                  r_degen;
    logic                  free;

    assign free    = !r_hv || (r_row == ROW_LAST && i_en);
    assign o_ready = free;

    // Holder valid and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_row <= ROW_FIRST;
        end else if (free && i_valid) begin
            r_hv  <= 1'b1;
            r_row <= ROW_FIRST;
        end else if (r_hv && i_en) begin
            if (r_row == ROW_LAST) r_hv <= 1'b0;
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && i_valid) begin
            r_m     <= i_m;
            r_n     <= i_n;
            r_degen <= i_degen;
        end
    end

    // Pick the current row's numerators; row 3 carries zeros
    always_comb begin
        o_num[0] = '0;
        o_num[1] = '0;
        o_num[2] = '0;
        case (r_row)
            2'd0: begin
                o_num[0] = r_m[0]; o_num[1] = r_m[1]; o_num[2] = r_m[2];
            end
            2'd1: begin
                o_num[0] = r_m[3]; o_num[1] = r_m[4]; o_num[2] = r_m[5];
            end
            2'd2: begin
                o_num[0] = r_m[6]; o_num[1] = r_m[7]; o_num[2] = r_m[8];
            end
            default: begin
                o_num[0] = '0;
            end
        endcase
    end

    assign o_valid      = r_hv;
    assign o_n          = r_n;
    assign o_side.row   = r_row;
    assign o_side.degen = r_degen;
    assign o_side.last  = (r_row == ROW_LAST);

endmodule

FILE: design/qrm_div_pipe.sv
// Three restoring-division lanes, one quotient bit per stage, with rounding
// and saturation at the tail. Depends on qrm_pkg.
`timescale 1ns / 1ps

module qrm_div_pipe
    import qrm_pkg::*;
#(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_side                 i_side,
    input  logic signed [2*W+1:0] i_num [3],
    input  logic [2*W:0]          i_n,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [OUT_W-1:0]      o_col [3]
);

    localparam int NS = F + 1;       // quotient-bit stages
    localparam int RW = 2 * W + 2;   // remainder width
    localparam int MW = 2 * W + 1;   // magnitude width
    localparam logic [F+1:0] CAP = (F+2)'(1) << F;

    // Stage 0: magnitude and sign
    logic          r0_v;
    t_side         r0_side;
    logic [MW-1:0] r0_mag [3];
    logic          r0_neg [3];
    logic [MW-1:0] r0_n;

    // Quotient-bit stages 1..NS
    logic          r_v    [1:NS];
    t_side         r_side [1:NS];
    logic [RW-1:0] r_rem  [1:NS][3];
    logic [F:0]    r_q    [1:NS][3];
    logic          r_neg  [1:NS][3];
    logic [MW-1:0] r_n    [1:NS];
    logic [RW-1:0] n_rem  [1:NS][3];
    logic [F:0]    n_q    [1:NS][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            for (int k = 1; k <= NS; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r0_v   <= i_valid;
            r_v[1] <= r0_v;
            for (int k = 2; k <= NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Absolute values
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_side <= i_side;
            r0_n    <= i_n;
            for (int l = 0; l < 3; l++) begin
                r0_neg[l] <= i_num[l][RW-1];
                r0_mag[l] <= i_num[l][RW-1] ? MW'(-i_num[l]) : MW'(i_num[l]);
            end
        end
    end

    // One compare and subtract per stage and lane
    always_comb begin
        logic [RW-1:0] t;
        logic [RW-1:0] nn;
        logic          ge;
        // First stage yields the integer bit
        nn = RW'(r0_n);
        for (int l = 0; l < 3; l++) begin
            t  = RW'(r0_mag[l]);
            ge = (t >= nn);
            n_rem[1][l] = ge ? t - nn : t;
            n_q[1][l]   = (F+1)'(ge);
        end
        for (int k = 2; k <= NS; k++) begin
            nn = RW'(r_n[k-1]);
            for (int l = 0; l < 3; l++) begin
                t  = r_rem[k-1][l] << 1;
                ge = (t >= nn);
                n_rem[k][l] = ge ? t - nn : t;
                n_q[k][l]   = {r_q[k-1][l][F-1:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= r0_side;
            r_n[1]    <= r0_n;
            for (int l = 0; l < 3; l++) r_neg[1][l] <= r0_neg[l];
            for (int k = 2; k <= NS; k++) begin
                r_side[k] <= r_side[k-1];
                r_n[k]    <= r_n[k-1];
                for (int l = 0; l < 3; l++) r_neg[k][l] <= r_neg[k-1][l];
            end
            for (int k = 1; k <= NS; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_q[k][l]   <= n_q[k][l];
                end
            end
        end
    end

    // Round half up on magnitude, saturate, apply sign
    always_comb begin
        logic [F+1:0] qf;
        logic [32:0]  ext;
        logic         rnd;
        for (int l = 0; l < 3; l++) begin
            rnd = ((r_rem[NS][l] << 1) >= RW'(r_n[NS]));
            qf  = {1'b0, r_q[NS][l]} + (F+2)'(rnd);
            if (qf > CAP) qf = CAP;
            ext = 33'(qf);
            if (r_neg[NS][l]) ext = -ext;
            o_col[l] = (r_side[NS].degen || r_side[NS].last) ? '0 : ext[OUT_W-1:0];
        end
    end

    assign o_valid = r_v[NS];
    assign o_side  = r_side[NS];

endmodule

FILE: design/quaternion_to_rotation_matrix.sv
// Path: product and sum stages, row issuer, divider magnitude and quotient-bit
// stages, output register. Throughput: one row per cycle unless i_m_tready
// stalls; the row issuer holds each quaternion for its four rows.
// Reset: synchronous active-low i_rst_n clears all valid bits; data regs are
// not reset. Depends on qrm_pkg, qrm_products, qrm_row_seq, qrm_div_pipe.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // row_index, col_zero, col_one, col_two, col_three from bit 0 up, zero padded
    output logic [71:0]                           o_m_tdata,
    output logic                                  o_m_tlast,
    // degenerate
    output logic                                  o_m_tuser
);

    localparam int W = IN_WIDTH;
    localparam int F = OUT_FRAC_BITS;
    localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(64'(1) << F);

    logic                  en;
    logic                  p_valid, p_ready, q_valid;
    logic signed [2*W+1:0] p_m [9];
    logic [2*W:0]          p_n, q_n;
    logic                  p_degen;
    t_side                 q_side, d_side;
    logic signed [2*W+1:0] q_num [3];
    logic                  d_valid;
    logic [OUT_W-1:0]      d_col [3];

    logic             r_ov;
    t_side            r_oside;
    logic [OUT_W-1:0] r_ocol [3];

    assign en = !r_ov || i_m_tready;

    qrm_products #(.W(W)) u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_w     (i_s_tdata[W-1:0]),
        .i_x     (i_s_tdata[2*W-1:W]),
        .i_y     (i_s_tdata[3*W-1:2*W]),
        .i_z     (i_s_tdata[4*W-1:3*W]),
        .o_valid (p_valid),
        .i_ready (p_ready),
        .o_m     (p_m),
        .o_n     (p_n),
        .o_degen (p_degen)
    );

    qrm_row_seq #(.W(W)) u_row_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .o_ready (p_ready),
        .i_m     (p_m),
        .i_n     (p_n),
        .i_degen (p_degen),
        .o_valid (q_valid),
        .o_side  (q_side),
        .o_num   (q_num),
        .o_n     (q_n)
    );

    qrm_div_pipe #(.W(W), .F(F)) u_div_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_side  (q_side),
        .i_num   (q_num),
        .i_n     (q_n),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_col   (d_col)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oside <= d_side;
            r_ocol  <= d_col;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_oside.last;
    assign o_m_tuser  = r_oside.degen;
    assign o_m_tdata  = {6'd0, (r_oside.last ? ONE_Q : {OUT_W{1'b0}}),
                         r_ocol[2], r_ocol[1], r_ocol[0], r_oside.row};

    `QRM_ASSERT(a_last_row, o_m_tvalid, o_m_tlast == (o_m_tdata[1:0] == ROW_LAST),
        "tlast does not match row 3")
    `QRM_ASSERT(a_degen_zero, o_m_tvalid && o_m_tuser, o_m_tdata[49:2] == '0,
        "degenerate row carries nonzero entries")
    `QRM_ASSERT_NEXT(a_row_step, r_ov && i_m_tready && !o_m_tlast && d_valid,
        o_m_tdata[1:0] == $past(o_m_tdata[1:0]) + 2'd1,
        "rows out of order")

endmodule

FILE: bench/testbench.sv
// Self-checking bench for quaternion_to_rotation_matrix: drives quaternions on the
// input stream, predicts the four matrix rows of each, and compares every row.
// Depends on qrm_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import qrm_pkg::*;

    localparam int IN_W  = 16;
    localparam int FRAC  = 14;
    localparam int LATENCY = 21;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [15:0] ONE_Q = 16'(1 << FRAC);

    typedef struct packed {
        logic [1:0]  row;
        logic [15:0] c0, c1, c2, c3;
        logic        last;
        logic        degen;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // quat_w, quat_x, quat_y, quat_z
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;   // row_index, col_zero..col_three, zero padded
    logic        o_m_tlast;
    logic        o_m_tuser;   // degenerate

    quaternion_to_rotation_matrix #(.IN_WIDTH(IN_W), .OUT_FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast), .o_m_tuser(o_m_tuser)
    );

    t_row        rows_due[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          send_gaps = 1;
    bit          recv_gaps = 1;
    bit          hold_rows = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // One entry: num/n in Q2.14, round half away from zero, capped at one
    function automatic logic [15:0] scaled_entry(longint num, longint n);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag << (FRAC + 1)) / n + 1) >>> 1;
        if (q > (1 << FRAC)) q = 1 << FRAC;
        return 16'((num < 0) ? -q : q);
    endfunction

    // Predict the four rows of one quaternion
    task automatic predict_rows(logic signed [15:0] w, x, y, z);
        longint ww, xx, yy, zz, n;
        longint m[3][3];
        t_row r;
        bit degen;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        degen = (n == 0);
        m[0][0] = ww + xx - yy - zz;
        m[0][1] = 2 * (longint'(x) * y - longint'(w) * z);
        m[0][2] = 2 * (longint'(x) * z + longint'(w) * y);
        m[1][0] = 2 * (longint'(x) * y + longint'(w) * z);
        m[1][1] = ww - xx + yy - zz;
        m[1][2] = 2 * (longint'(y) * z - longint'(w) * x);
        m[2][0] = 2 * (longint'(x) * z - longint'(w) * y);
        m[2][1] = 2 * (longint'(y) * z + longint'(w) * x);
        m[2][2] = ww - xx - yy + zz;
        for (int i = 0; i < 4; i++) begin
            r = '0;
            r.row = 2'(i);
            r.degen = degen;
            if (i == 3) begin
                r.c3 = ONE_Q;
                r.last = 1'b1;
            end else if (!degen) begin
                r.c0 = scaled_entry(m[i][0], n);
                r.c1 = scaled_entry(m[i][1], n);
                r.c2 = scaled_entry(m[i][2], n);
            end
            rows_due.push_back(r);
        end
    endtask

    // Offer one quaternion and wait for its transfer; valid drops only in a gap
    task automatic send_quat(logic [15:0] w, x, y, z);
        if (send_gaps)
            while ($urandom_range(99) < 35) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x, w};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_rows(w, x, y, z);
    endtask

    // Receiver readiness
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rows)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= recv_gaps ? ($urandom_range(99) >= 35) : 1'b1;
    end

    // Row checker
    always @(posedge i_clk) begin
        t_row got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[1:0], o_m_tdata[17:2], o_m_tdata[33:18], o_m_tdata[49:34],
                   o_m_tdata[65:50], o_m_tlast, o_m_tuser};
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row %h", got);
            end else begin
                want = rows_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"row mismatch: expected row=%0d %h %h %h %h l=%b d=%b,",
                                  " got row=%0d %h %h %h %h l=%b d=%b"},
                                 want.row, want.c0, want.c1, want.c2, want.c3, want.last,
                                 want.degen, got.row, got.c0, got.c1, got.c2, got.c3,
                                 got.last, got.degen);
                end
            end
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // Extremes, axes, zero quaternion, sign patterns
    task automatic test_directed();
        send_quat(0, 0, 0, 0);
        send_quat(1, 0, 0, 0);
        send_quat(0, 1, 0, 0);
        send_quat(0, 0, 1, 0);
        send_quat(0, 0, 0, 1);
        send_quat(16'h8000, 0, 0, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(1, 1, 0, 0);
        send_quat(16'hffff, 1, 1, 16'hffff);
        send_quat(3, 1, 1, 1);
        send_quat(0, 16'h5555, 16'haaaa, 16'h0001);
        send_quat(16'h7fff, 1, 0, 0);
        send_quat(16'h8000, 0, 0, 16'h7fff);
        send_quat(0, 0, 0, 0);
    endtask

    // Random magnitudes: full range, small, near-axis
    task automatic test_random(int count);
        logic [15:0] q[4];
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: foreach (q[k]) q[k] = 16'($signed(8'($urandom)));
                1: begin
                    foreach (q[k]) q[k] = 16'($signed(4'($urandom)));
                    q[$urandom_range(3)] = rnd16();
                end
                default: foreach (q[k]) q[k] = rnd16();
            endcase
            if ($urandom_range(49) == 0) q = '{0, 0, 0, 0};
            send_quat(q[0], q[1], q[2], q[3]);
        end
    endtask

    // Receiver stalls long while the sender keeps offering
    task automatic test_backpressure();
        hold_rows = 1;
        fork
            begin
                repeat (150) @(posedge i_clk);
                hold_rows = 0;
            end
        join_none
        send_gaps = 0;
        test_random(20);
        send_gaps = 1;
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(90);
        send_gaps = 0;
        recv_gaps = 0;
        test_random(40);
        send_gaps = 1;
        recv_gaps = 1;
        test_random(40);
        wait_drain();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/qrm_pkg.sv
design/qrm_products.sv
design/qrm_row_seq.sv
design/qrm_div_pipe.sv
design/quaternion_to_rotation_matrix.sv
bench/testbench.sv
